FILE: src/wavetable_sine_oscillator_top_macros.svh
// Assertion macros for the wavetable sine oscillator.
// Assertions use the clk_i and rst_ni names of the including module.
`ifndef WAVETABLE_SINE_OSCILLATOR_TOP_MACROS_SVH
`define WAVETABLE_SINE_OSCILLATOR_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define WSO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSO_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WSO_ASSERT_IMP(label, ante, cons, msg)
`define WSO_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

FILE: src/wso_pkg.sv
// Shared constants, types and the constant sine table of the oscillator.
// No dependencies; the design modules refer to this package by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package wso_pkg;

  // Table and number formats.
  localparam int TABLE_DEPTH   = 1024;
  localparam int FRACTION_BITS = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int IDX_BITS      = $clog2(TABLE_DEPTH);
  localparam int QTR_BITS      = IDX_BITS - 2;
  localparam int QUARTER_DEPTH = TABLE_DEPTH / 4;
  localparam int MAG_BITS      = SAMPLE_BITS - 1;
  localparam int PHASE_BITS    = IDX_BITS + FRACTION_BITS;

  // Configuration registers.
  localparam int STEP_BITS     = 26;
  localparam int AMP_BITS      = 16;
  localparam int AMP_FRAC_BITS = 15;
  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1889645);
  localparam logic [AMP_BITS-1:0]  AMP_RESET  = '0;
  localparam int CFG_DATA_BITS = 32;
  localparam int PADDR_BITS    = 3;
  localparam int REG_SEL_BIT   = 2;
  localparam logic REG_PHASE_STEP = 1'b0;
  localparam logic REG_AMPLITUDE  = 1'b1;

  // Serial multiplier geometry.
  localparam int DIGIT_BITS   = 4;
  localparam int MUL_A_BITS   = SAMPLE_BITS + 1;
  localparam int MUL_B_BITS   = (FRACTION_BITS > AMP_BITS) ? FRACTION_BITS : AMP_BITS;
  localparam int MUL_DIGITS   = (MUL_B_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int MUL_B_PAD    = MUL_DIGITS * DIGIT_BITS;
  localparam int PROD_BITS    = MUL_A_BITS + MUL_B_PAD;
  localparam int PP_BITS      = MUL_A_BITS + DIGIT_BITS + 1;
  localparam int MUL_CNT_BITS = $clog2(MUL_DIGITS + 1);

  // Rounding and saturation constants on the product width.
  localparam logic signed [PROD_BITS-1:0] INTERP_HALF = PROD_BITS'(1) << (FRACTION_BITS - 1);
  localparam logic signed [PROD_BITS-1:0] GAIN_HALF   = PROD_BITS'(1) << (AMP_FRAC_BITS - 1);
  localparam logic signed [PROD_BITS-1:0] SAMPLE_MAX  = (PROD_BITS'(1) << (SAMPLE_BITS - 1))
                                                        - PROD_BITS'(1);
  localparam logic signed [PROD_BITS-1:0] SAMPLE_MIN  = ~SAMPLE_MAX;

  // Fixed-point angle constants used while building the table.
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Register file contents handed to the datapath.
  typedef struct packed {
    logic [STEP_BITS-1:0] phase_step;
    logic [AMP_BITS-1:0]  amplitude;
  } wso_cfg_t;

  // Start request for the serial multiplier.
  typedef struct packed {
    logic                         start;
    logic signed [MUL_A_BITS-1:0] a;
    logic [MUL_B_PAD-1:0]         b;
  } mul_req_t;

  typedef logic [QUARTER_DEPTH-1:0][MAG_BITS-1:0] quarter_rom_t;

  // Q30 sine on the first quadrant, Taylor series through the x^17 term.
  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > $signed(ONE_Q30)) begin
      sum = $signed(ONE_Q30);
    end
    return $unsigned(sum);
  endfunction

  // Magnitude of table entry k for k in the first quadrant, peak included.
  function automatic logic [MAG_BITS-1:0] rom_mag(input int k);
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] quad;
    logic [63:0] full;
    logic [63:0] mag;
    t    = (64'(k) << 32) / TABLE_DEPTH;
    quad = (t >> 30) & 64'd3;
    r    = t & (ONE_Q30 - 64'd1);
    if (quad[0]) begin
      r = ONE_Q30 - r;
    end
    full = (64'd1 << MAG_BITS) - 64'd1;
    mag  = (sin_q30((r * HALF_PI_Q30) >> 30) * full + (64'd1 << 29)) >> 30;
    return mag[MAG_BITS-1:0];
  endfunction

  function automatic quarter_rom_t build_quarter();
    quarter_rom_t tbl;
    for (int k = 0; k < QUARTER_DEPTH; k++) begin
      tbl[k] = rom_mag(k);
    end
    return tbl;
  endfunction

  // Quarter-wave table, evaluated at elaboration.
  localparam quarter_rom_t QUARTER_ROM = build_quarter();
  localparam logic [MAG_BITS-1:0] PEAK_MAG = rom_mag(QUARTER_DEPTH);

  // Full-period table entry, folded onto the quarter-wave table.
  function automatic logic signed [SAMPLE_BITS-1:0] sine_at(input logic [IDX_BITS-1:0] idx);
    logic [1:0]                    quad;
    logic [QTR_BITS-1:0]           j;
    logic [QTR_BITS:0]             k;
    logic [MAG_BITS-1:0]           mag;
    logic signed [SAMPLE_BITS-1:0] sv;
    quad = idx[IDX_BITS-1 -: 2];
    j    = idx[QTR_BITS-1:0];
    k    = quad[0] ? ((QTR_BITS+1)'(QUARTER_DEPTH) - {1'b0, j}) : {1'b0, j};
    mag  = k[QTR_BITS] ? PEAK_MAG : QUARTER_ROM[k[QTR_BITS-1:0]];
    sv   = $signed({1'b0, mag});
    return quad[1] ? -sv : sv;
  endfunction

endpackage

FILE: src/wavetable_sine_oscillator_top.sv
// Sine oscillator with linear interpolation. One word in gives one word out.
// A word makes two passes through the shared 4-bit digit-serial multiplier, plus lookup,
// rounding and hand-off; no new word is accepted until the last one is in the output register.
// The result is held in an output register until the sink takes it.
// Reset clears the phase, sets the step to 1889645 and the amplitude to zero.
// The sine table is constant logic and needs no initialization pass.
`timescale 1ns / 1ps
`include "wavetable_sine_oscillator_top_macros.svh"

module wavetable_sine_oscillator_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   last_frame_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [wso_pkg::SAMPLE_BITS-1:0] sample_left_o,
  output logic signed [wso_pkg::SAMPLE_BITS-1:0] sample_right_o,
  output logic                                   end_of_block_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [wso_pkg::PADDR_BITS-1:0]         paddr,
  input  logic [wso_pkg::CFG_DATA_BITS-1:0]      pwdata,
  output logic [wso_pkg::CFG_DATA_BITS-1:0]      prdata,
  output logic                                   pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL1 = 2'd1;
  localparam logic [1:0] S_MUL2 = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                             state_q;
  logic [1:0]                             state_d;
  logic [wso_pkg::PHASE_BITS-1:0]         phase_q;
  logic [wso_pkg::PHASE_BITS-1:0]         phase_d;
  logic signed [wso_pkg::SAMPLE_BITS-1:0] y1_q;
  logic                                   last_q;
  logic signed [wso_pkg::SAMPLE_BITS-1:0] res_q;
  logic signed [wso_pkg::SAMPLE_BITS-1:0] out_sample_q;
  logic                                   out_eob_q;
  logic                                   out_valid_q;

  logic                                   in_accept;
  logic                                   out_free;
  wso_pkg::wso_cfg_t                      cfg;
  logic [wso_pkg::IDX_BITS-1:0]           idx;
  logic signed [wso_pkg::SAMPLE_BITS-1:0] y1;
  logic signed [wso_pkg::MUL_A_BITS-1:0]  diff;
  wso_pkg::mul_req_t                      mul_req;
  logic signed [wso_pkg::PROD_BITS-1:0]   prod;
  logic                                   mul_done;
  logic signed [wso_pkg::PROD_BITS-1:0]   rnd1;
  logic signed [wso_pkg::PROD_BITS-1:0]   shift1;
  logic signed [wso_pkg::MUL_A_BITS-1:0]  interp;
  logic signed [wso_pkg::PROD_BITS-1:0]   rnd2;
  logic signed [wso_pkg::PROD_BITS-1:0]   shift2;
  logic signed [wso_pkg::SAMPLE_BITS-1:0] gain_sat;

  // Configuration registers.
  wso_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshakes: one word in flight, the output register decouples the sink.
  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Phase split into table index and interpolation fraction.
  assign idx     = phase_q[wso_pkg::PHASE_BITS-1 -: wso_pkg::IDX_BITS];
  assign phase_d = phase_q + wso_pkg::PHASE_BITS'(cfg.phase_step);

  wso_sine_lookup u_lookup (
    .idx_i  (idx),
    .y1_o   (y1),
    .diff_o (diff)
  );

  // Interpolation: y1 plus the rounded slope times fraction.
  assign rnd1   = prod + wso_pkg::INTERP_HALF;
  assign shift1 = rnd1 >>> wso_pkg::FRACTION_BITS;
  assign interp = wso_pkg::MUL_A_BITS'(shift1)
                + $signed({y1_q[wso_pkg::SAMPLE_BITS-1], y1_q});

  // Gain: rounded unsigned Q1.15 scaling, saturated to the sample range.
  assign rnd2   = prod + wso_pkg::GAIN_HALF;
  assign shift2 = rnd2 >>> wso_pkg::AMP_FRAC_BITS;
  always_comb begin
    if (shift2 > wso_pkg::SAMPLE_MAX) begin
      gain_sat = wso_pkg::SAMPLE_MAX[wso_pkg::SAMPLE_BITS-1:0];
    end else if (shift2 < wso_pkg::SAMPLE_MIN) begin
      gain_sat = wso_pkg::SAMPLE_MIN[wso_pkg::SAMPLE_BITS-1:0];
    end else begin
      gain_sat = shift2[wso_pkg::SAMPLE_BITS-1:0];
    end
  end

  // The shared multiplier runs slope times fraction, then sample times amplitude.
  always_comb begin
    mul_req.start = in_accept || ((state_q == S_MUL1) && mul_done);
    if (state_q == S_IDLE) begin
      mul_req.a = diff;
      mul_req.b = wso_pkg::MUL_B_PAD'(phase_q[wso_pkg::FRACTION_BITS-1:0]);
    end else begin
      mul_req.a = interp;
      mul_req.b = wso_pkg::MUL_B_PAD'(cfg.amplitude);
    end
  end

  wso_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .prod_o (prod),
    .done_o (mul_done)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_accept) state_d = S_MUL1;
      S_MUL1: if (mul_done) state_d = S_MUL2;
      S_MUL2: if (mul_done) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state: sequencer, phase accumulator and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        phase_q <= phase_d;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      y1_q   <= y1;
      last_q <= last_frame_i;
    end
    if ((state_q == S_MUL2) && mul_done) begin
      res_q <= gain_sat;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_sample_q <= res_q;
      out_eob_q    <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_left_o  = out_sample_q;
  assign sample_right_o = out_sample_q;
  assign end_of_block_o = out_eob_q;

  // A finished product only shows up while the sequencer is waiting for one.
  `WSO_ASSERT_IMP(a_done_in_mul, mul_done, (state_q == S_MUL1) || (state_q == S_MUL2), "multiplier finished outside a multiply state")
  // The phase moves only when a word is accepted.
  `WSO_ASSERT_NXT(a_phase_hold, !in_accept, $stable(phase_q), "phase changed without an accepted word")
  // An accepted word starts the first multiply and blocks further input.
  `WSO_ASSERT_NXT(a_accept_mul1, in_accept, (state_q == S_MUL1) && !in_ready_o, "accepted word did not start the slope multiply")

endmodule

FILE: src/wso_apb_regs.sv
// APB-style register file holding the phase step and amplitude.
// Depends on wso_pkg for widths, reset values and register selects.
`timescale 1ns / 1ps

module wso_apb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wso_pkg::PADDR_BITS-1:0]     paddr,
  input  logic [wso_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [wso_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  output wso_pkg::wso_cfg_t                  cfg_o
);

  logic                               wr_en;
  logic [wso_pkg::STEP_BITS-1:0]      phase_step_q;
  logic [wso_pkg::AMP_BITS-1:0]       amplitude_q;

  // A write lands in the access phase; the port never stalls.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register storage; bits above each register's width are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= wso_pkg::STEP_RESET;
      amplitude_q  <= wso_pkg::AMP_RESET;
    end else if (wr_en) begin
      case (paddr[wso_pkg::REG_SEL_BIT])
        wso_pkg::REG_PHASE_STEP: phase_step_q <= pwdata[wso_pkg::STEP_BITS-1:0];
        wso_pkg::REG_AMPLITUDE:  amplitude_q  <= pwdata[wso_pkg::AMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (paddr[wso_pkg::REG_SEL_BIT])
      wso_pkg::REG_PHASE_STEP: prdata = wso_pkg::CFG_DATA_BITS'(phase_step_q);
      wso_pkg::REG_AMPLITUDE:  prdata = wso_pkg::CFG_DATA_BITS'(amplitude_q);
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o.phase_step = phase_step_q;
  assign cfg_o.amplitude  = amplitude_q;

endmodule

FILE: src/wso_sine_lookup.sv
// Sine table lookup: the entry at the phase index, and the step to the next entry.
// Depends on wso_pkg for the quarter-wave table and its folding function.
`timescale 1ns / 1ps

module wso_sine_lookup (
  input  logic [wso_pkg::IDX_BITS-1:0]           idx_i,
  output logic signed [wso_pkg::SAMPLE_BITS-1:0] y1_o,
  output logic signed [wso_pkg::MUL_A_BITS-1:0]  diff_o
);

  logic [wso_pkg::IDX_BITS-1:0]           nxt_idx;
  logic signed [wso_pkg::SAMPLE_BITS-1:0] y2;

  // The next index wraps naturally at the end of the table.
  assign nxt_idx = idx_i + wso_pkg::IDX_BITS'(1);

  assign y1_o = wso_pkg::sine_at(idx_i);
  assign y2   = wso_pkg::sine_at(nxt_idx);

  // Slope between neighbors, one bit wider than a sample.
  assign diff_o = $signed({y2[wso_pkg::SAMPLE_BITS-1], y2})
                - $signed({y1_o[wso_pkg::SAMPLE_BITS-1], y1_o});

endmodule

FILE: src/wso_serial_mul.sv
// Digit-serial signed-by-unsigned multiplier, one multiplier digit per cycle.
// Depends on wso_pkg for operand widths, digit size and the request struct.
`timescale 1ns / 1ps

module wso_serial_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  wso_pkg::mul_req_t                    req_i,
  output logic signed [wso_pkg::PROD_BITS-1:0] prod_o,
  output logic                                 done_o
);

  logic signed [wso_pkg::MUL_A_BITS-1:0] a_q;
  logic [wso_pkg::MUL_B_PAD-1:0]         b_q;
  logic signed [wso_pkg::PROD_BITS-1:0]  acc_q;
  logic signed [wso_pkg::PROD_BITS-1:0]  acc_d;
  logic [wso_pkg::MUL_CNT_BITS-1:0]      cnt_q;
  logic                                  done_q;
  logic                                  busy;
  logic [wso_pkg::DIGIT_BITS-1:0]        digit;
  logic signed [wso_pkg::PP_BITS-1:0]    pp;

  assign busy  = (cnt_q != '0);

  // Multiplier digits are consumed most significant first.
  assign digit = b_q[wso_pkg::MUL_B_PAD-1 -: wso_pkg::DIGIT_BITS];
  assign pp    = a_q * $signed({1'b0, digit});
  assign acc_d = (acc_q <<< wso_pkg::DIGIT_BITS) + wso_pkg::PROD_BITS'(pp);

  // Digit counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy && (cnt_q == wso_pkg::MUL_CNT_BITS'(1));
      if (req_i.start) begin
        cnt_q <= wso_pkg::MUL_CNT_BITS'(wso_pkg::MUL_DIGITS);
      end else if (busy) begin
        cnt_q <= cnt_q - wso_pkg::MUL_CNT_BITS'(1);
      end
    end
  end

  // Operand shift register and accumulator.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy) begin
      b_q   <= b_q << wso_pkg::DIGIT_BITS;
      acc_q <= acc_d;
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the wavetable sine oscillator top level.
// Depends on wso_pkg and wavetable_sine_oscillator_top; predicts frames with its own model.
`timescale 1ns / 1ps

module tb_top;
  import wso_pkg::*;

  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_PHASES      = 6;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int NUM_DIR         = 24;

  // Byte addresses of the two registers.
  localparam logic [PADDR_BITS-1:0] ADDR_PHASE_STEP = {REG_PHASE_STEP, 2'b00};
  localparam logic [PADDR_BITS-1:0] ADDR_AMPLITUDE  = {REG_AMPLITUDE, 2'b00};

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned QUARTER_RAD = 64'd1686629713;
  localparam longint          SAT_HIGH    = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint          SAT_LOW     = -SAT_HIGH - 1;

  typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    logic [PADDR_BITS-1:0]         addr;
    logic [CFG_DATA_BITS-1:0]      data;
    logic                          last;
    logic                          typed;
    logic signed [SAMPLE_BITS-1:0] typed_sample;
  } dir_row_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          eob;
  } frame_result_t;

  // Directed rows: typed samples only where the gain is zero.
  dir_row_t dir_rows [NUM_DIR] = '{
    '{ROW_FRAME, '0, '0, 1'b0, 1'b1, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b1, 1'b1, 16'sd0},
    '{ROW_WRITE, ADDR_AMPLITUDE,  32'hFFFF_8000, 1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b1, 1'b0, 16'sd0},
    '{ROW_WRITE, ADDR_PHASE_STEP, 32'h0000_0000, 1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, ADDR_PHASE_STEP, 32'h0001_0000, 1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b1, 1'b0, 16'sd0},
    '{ROW_WRITE, ADDR_AMPLITUDE,  32'h0000_FFFF, 1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, ADDR_PHASE_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, ADDR_PHASE_STEP, 32'h0400_0000, 1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b1, 1'b0, 16'sd0},
    '{ROW_WRITE, ADDR_PHASE_STEP, 32'h0200_0000, 1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, ADDR_AMPLITUDE,  32'h0000_0000, 1'b0, 1'b0, 16'sd0},
    '{ROW_FRAME, '0, '0, 1'b1, 1'b1, 16'sd0}
  };

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_ready_o;
  logic                          last_frame_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i  = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_left_o;
  logic signed [SAMPLE_BITS-1:0] sample_right_o;
  logic                          end_of_block_o;
  logic                          psel         = 1'b0;
  logic                          penable      = 1'b0;
  logic                          pwrite       = 1'b0;
  logic [PADDR_BITS-1:0]         paddr        = '0;
  logic [CFG_DATA_BITS-1:0]      pwdata       = '0;
  logic [CFG_DATA_BITS-1:0]      prdata;
  logic                          pready;

  // Predictor state: phase, registers and the full sine period.
  logic [PHASE_BITS-1:0] osc_phase;
  logic [STEP_BITS-1:0]  osc_step;
  logic [AMP_BITS-1:0]   osc_amp;
  int                    sine_tbl [TABLE_DEPTH];

  frame_result_t pending_frames [$];
  int            fail_count     = 0;
  int            frames_checked = 0;
  int            reg_writes     = 0;
  int            idle_cycles    = 0;
  int            stall_left     = 0;
  int            calm_left      = 0;

  wavetable_sine_oscillator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .last_frame_i   (last_frame_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_left_o  (sample_left_o),
    .sample_right_o (sample_right_o),
    .end_of_block_o (end_of_block_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // One table entry: fold the angle into a quarter turn, Taylor series in Q30, round.
  function automatic int sine_entry(input int i);
    longint unsigned turn;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned mag;
    longint          acc;
    turn = i;
    turn = (turn << 32) / TABLE_DEPTH;
    quad = (turn >> 30) & 64'd3;
    r    = turn & (Q30_ONE - 64'd1);
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    x    = (r * QUARTER_RAD) >> 30;
    x2   = (x * x) >> 30;
    acc  = x;
    term = x;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(Q30_ONE)) begin
      acc = longint'(Q30_ONE);
    end
    mag = acc;
    mag = (mag * longint'(SAT_HIGH) + (64'd1 << 29)) >> 30;
    return quad[1] ? -int'(mag) : int'(mag);
  endfunction

  // Interpolated, scaled and saturated sample for a phase.
  function automatic logic signed [SAMPLE_BITS-1:0] predict_sample(
      input logic [PHASE_BITS-1:0] ph);
    logic [IDX_BITS-1:0] idx;
    longint              y1;
    longint              y2;
    longint              frac;
    longint              gain;
    longint              interp;
    longint              scaled;
    idx    = ph[PHASE_BITS-1 -: IDX_BITS];
    y1     = sine_tbl[idx];
    y2     = sine_tbl[IDX_BITS'(idx + 1'b1)];
    frac   = ph[FRACTION_BITS-1:0];
    gain   = osc_amp;
    interp = y1 + (((y2 - y1) * frac + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS);
    scaled = (interp * gain + (64'sd1 <<< (AMP_FRAC_BITS - 1))) >>> AMP_FRAC_BITS;
    if (scaled > SAT_HIGH) begin
      scaled = SAT_HIGH;
    end
    if (scaled < SAT_LOW) begin
      scaled = SAT_LOW;
    end
    return SAMPLE_BITS'(scaled);
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  // Present one word and hold it until accepted; the expectation is queued at acceptance.
  task automatic send_frame(input logic last, input logic typed,
                            input logic signed [SAMPLE_BITS-1:0] typed_sample);
    frame_result_t want;
    in_valid_i   <= 1'b1;
    last_frame_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    want.sample = typed ? typed_sample : predict_sample(osc_phase);
    want.eob    = last;
    pending_frames.push_back(want);
    // The period is exactly 2^PHASE_BITS, so truncation is the modulo.
    osc_phase = PHASE_BITS'(osc_phase + osc_step);
  endtask

  task automatic idle_gap(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop sending and wait until every expected word has come back.
  task automatic settle();
    idle_gap(1);
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write followed by a read-back of the stored value.
  task automatic reg_write(input logic [PADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] data);
    logic [CFG_DATA_BITS-1:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_PHASE_STEP) begin
      osc_step = data[STEP_BITS-1:0];
    end else begin
      osc_amp = data[AMP_BITS-1:0];
    end
    stored = (addr == ADDR_PHASE_STEP) ? CFG_DATA_BITS'(osc_step) : CFG_DATA_BITS'(osc_amp);
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== stored) begin
      report_mismatch("register read-back", stored, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: random stalls of random length, with calm stretches in between.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (calm_left != 0) begin
        calm_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 25);
        if ($urandom_range(0, 7) == 0) begin
          calm_left = $urandom_range(20, 200);
        end
      end
    end
  end

  // Compare each accepted output word with the oldest expectation.
  always @(posedge clk_i) begin : out_check
    frame_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_frames.size() == 0) begin
        fail_count++;
        $display("%0t: output word with nothing expected, left %0d right %0d",
                 $time, sample_left_o, sample_right_o);
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (sample_left_o !== want.sample) begin
          report_mismatch("sample_left", want.sample, sample_left_o);
        end
        if (sample_right_o !== want.sample) begin
          report_mismatch("sample_right", want.sample, sample_right_o);
        end
        if (end_of_block_o !== want.eob) begin
          report_mismatch("end_of_block", want.eob, end_of_block_o);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake or register access.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d words outstanding",
               $time, idle_cycles, pending_frames.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus: directed table, then random phases with fresh register settings.
  initial begin
    int burst_left;
    int step_kind;
    int amp_kind;
    logic [CFG_DATA_BITS-1:0] step_val;
    logic [CFG_DATA_BITS-1:0] amp_val;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sine_tbl[i] = sine_entry(i);
    end
    osc_phase  = '0;
    osc_step   = STEP_RESET;
    osc_amp    = AMP_RESET;
    burst_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int n = 0; n < NUM_DIR; n++) begin
      if (dir_rows[n].kind == ROW_WRITE) begin
        settle();
        reg_write(dir_rows[n].addr, dir_rows[n].data);
      end else begin
        send_frame(dir_rows[n].last, dir_rows[n].typed, dir_rows[n].typed_sample);
        if ($urandom_range(0, 2) == 0) begin
          idle_gap($urandom_range(1, 13));
        end
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      step_kind = $urandom_range(0, 4);
      case (step_kind)
        0:       step_val = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        1:       step_val = $urandom_range(1, 1 << 17);
        2:       step_val = $urandom;
        3:       step_val = 32'($urandom_range(0, TABLE_DEPTH)) << FRACTION_BITS;
        default: step_val = STEP_RESET + $urandom_range(0, 1 << 20);
      endcase
      amp_kind = $urandom_range(0, 3);
      case (amp_kind)
        0:       amp_val = 32'h0000_8000;
        1:       amp_val = 32'h0000_FFFF;
        2:       amp_val = $urandom_range(0, 32768);
        default: amp_val = $urandom;
      endcase
      reg_write(ADDR_PHASE_STEP, step_val);
      reg_write(ADDR_AMPLITUDE, amp_val);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Every other phase the sender stops midway until the block has drained.
        if (n == ITEMS_PER_PHASE / 2 && ph % 2 == 0) begin
          settle();
        end
        send_frame($urandom_range(0, 7) == 0, 1'b0, '0);
        if (burst_left == 0) begin
          idle_gap($urandom_range(1, 30));
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end

    idle_gap(1);
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Checked %0d frames over %0d register writes, gains up to 65535,", frames_checked,
             reg_writes);
    $display("steps from zero to full scale, with random sender gaps and receiver stalls.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
